/* hdl/rip_pkg.sv */
// ----------------------------------------------------------------------------
// rip_pkg
// Shared constants and helper functions for the radix integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rip_pkg;

	localparam int unsigned MAX_LEN = 4096;
	localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
	localparam int unsigned VAL_W   = 64;
	localparam int unsigned BASE_W  = 6;
	localparam int unsigned CHAR_W  = 8;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

	localparam logic [0:0] RADIX_IDX = 1'b0;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

	typedef struct packed {
		logic              valid;
		logic [BASE_W-1:0] value;
	} digit_t;

	function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
		digit_t d;
		d.valid = 1'b1;
		d.value = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d.value = BASE_W'(c - CH_ZERO);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d.value = BASE_W'(c - CH_UA) + BASE_DEC;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d.value = BASE_W'(c - CH_LA) + BASE_DEC;
		end else begin
			d.valid = 1'b0;
		end
		return d;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
		input logic [1:0] k);
		logic [CNT_W:0] sum;
		sum = {1'b0, cnt} + (CNT_W + 1)'(k);
		if (sum > (CNT_W + 1)'(MAX_LEN)) begin
			return MAX_CNT;
		end
		return sum[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hdl/radix_integer_parser.sv */
// ----------------------------------------------------------------------------
// radix_integer_parser
// Streaming unsigned integer parser, one character per transfer, that skips
// whitespace, takes a sign and a base prefix and accumulates digits.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   -------   ---------------------   -----------------------------------
//   input     char_valid/char_ready   ch, last, no_char
//   result    res_valid/res_ready     consumed, value, value_written
//   config    APB (psel..pready)      radix at byte address 0
//
// A character is taken every cycle unless the input side is held. It passes
// an input register, then the parse logic, whose 64-by-6 multiply-accumulate
// sets the cycle, updates the parser state and, on a last transfer, loads
// the result register. A stalled result only holds the input side when a
// further last transfer needs the result register. Reset clears all control
// state and sets radix to 0.
//
`default_nettype none

module radix_integer_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           char_valid,
	output logic                                char_ready,
	input  wire logic [rip_pkg::CHAR_W-1:0]     ch,
	input  wire logic                           last,
	input  wire logic                           no_char,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output logic [rip_pkg::CNT_W-1:0]           consumed,
	output logic [rip_pkg::VAL_W-1:0]           value,
	output logic                                value_written,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [2:0]                     paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	typedef enum logic [2:0] {
		PH_WS,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	logic [rip_pkg::BASE_W-1:0] radix_q;

	logic                       valid_s1;
	logic [rip_pkg::CHAR_W-1:0] ch_s1;
	logic                       last_s1;
	logic                       no_char_s1;

	phase_t                     phase_q;
	logic [rip_pkg::VAL_W-1:0]  acc_q;
	logic                       neg_q;
	logic [rip_pkg::BASE_W-1:0] base_q;
	logic [rip_pkg::CNT_W-1:0]  count_q;
	logic                       zp_q;

	logic                       res_valid_q;
	logic [rip_pkg::CNT_W-1:0]  consumed_q;
	logic [rip_pkg::VAL_W-1:0]  value_q;
	logic                       written_q;

	logic                       res_free;
	logic                       advance;

	phase_t                     phase_d;
	logic [rip_pkg::VAL_W-1:0]  acc_d;
	logic                       neg_d;
	logic [rip_pkg::BASE_W-1:0] base_d;
	logic [rip_pkg::CNT_W-1:0]  count_d;
	logic                       zp_d;
	logic [rip_pkg::CNT_W-1:0]  fin_count;
	logic [rip_pkg::VAL_W-1:0]  fin_value;
	logic                       take_first;
	logic                       take_dig;
	logic                       is_ws;
	rip_pkg::digit_t            dig;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == rip_pkg::RADIX_IDX) ?
		{{(32 - rip_pkg::BASE_W){1'b0}}, radix_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rip_pkg::BASE_AUTO;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == rip_pkg::RADIX_IDX) begin
			radix_q <= pwdata[rip_pkg::BASE_W-1:0];
		end
	end

	assign res_free   = !res_valid_q || res_ready;
	assign advance    = valid_s1 && (!last_s1 || res_free);
	assign char_ready = !valid_s1 || advance;

	assign dig   = rip_pkg::digit_of(ch_s1);
	assign is_ws = (ch_s1 == rip_pkg::CH_SPACE)
		|| (ch_s1 >= rip_pkg::CH_TAB && ch_s1 <= rip_pkg::CH_CR);

	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		neg_d      = neg_q;
		base_d     = base_q;
		count_d    = count_q;
		zp_d       = zp_q;
		take_first = 1'b0;
		take_dig   = 1'b0;

		if (!no_char_s1) begin
			if (count_q >= rip_pkg::MAX_CNT) begin
				phase_d = PH_DONE;
			end else begin
				case (phase_q)
					PH_WS: begin
						if (is_ws) begin
							count_d = rip_pkg::sat_add(count_q, 2'd1);
						end else if (ch_s1 == rip_pkg::CH_PLUS
							|| ch_s1 == rip_pkg::CH_MINUS) begin
							neg_d   = (ch_s1 == rip_pkg::CH_MINUS);
							count_d = rip_pkg::sat_add(count_q, 2'd1);
							phase_d = PH_SIGNED;
						end else begin
							take_first = 1'b1;
						end
					end
					PH_SIGNED: begin
						take_first = 1'b1;
					end
					PH_ZERO: begin
						zp_d    = 1'b0;
						phase_d = PH_DIGITS;
						if (ch_s1 == rip_pkg::CH_LX || ch_s1 == rip_pkg::CH_UX) begin
							count_d = rip_pkg::sat_add(count_q, 2'd2);
							base_d  = rip_pkg::BASE_HEX;
						end else begin
							count_d  = rip_pkg::sat_add(count_q, 2'd1);
							take_dig = 1'b1;
						end
					end
					PH_DIGITS: begin
						take_dig = 1'b1;
					end
					default: begin
					end
				endcase
			end

			if (take_first) begin
				if ((radix_q == rip_pkg::BASE_AUTO || radix_q == rip_pkg::BASE_HEX)
					&& ch_s1 == rip_pkg::CH_ZERO) begin
					base_d  = (radix_q == rip_pkg::BASE_AUTO) ?
						rip_pkg::BASE_OCT : rip_pkg::BASE_HEX;
					zp_d    = 1'b1;
					phase_d = PH_ZERO;
				end else begin
					base_d   = (radix_q == rip_pkg::BASE_AUTO) ? rip_pkg::BASE_DEC : radix_q;
					phase_d  = PH_DIGITS;
					take_dig = 1'b1;
				end
			end

			if (take_dig) begin
				if (count_d >= rip_pkg::MAX_CNT || !dig.valid || dig.value >= base_d) begin
					phase_d = PH_DONE;
				end else begin
					acc_d   = rip_pkg::VAL_W'(acc_q * rip_pkg::VAL_W'(base_d))
						+ rip_pkg::VAL_W'(dig.value);
					count_d = rip_pkg::sat_add(count_d, 2'd1);
				end
			end
		end

		fin_count = zp_d ? rip_pkg::sat_add(count_d, 2'd1) : count_d;
		if (fin_count == '0) begin
			fin_value = '0;
		end else if (neg_d) begin
			fin_value = rip_pkg::VAL_W'(0) - acc_d;
		end else begin
			fin_value = acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			ch_s1      <= ch;
			last_s1    <= last;
			no_char_s1 <= no_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			count_q <= '0;
			zp_q    <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= PH_WS;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				base_q  <= '0;
				count_q <= '0;
				zp_q    <= 1'b0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				base_q  <= base_d;
				count_q <= count_d;
				zp_q    <= zp_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			consumed_q <= fin_count;
			value_q    <= fin_value;
			written_q  <= (fin_count != '0);
		end
	end

	assign res_valid     = res_valid_q;
	assign consumed      = consumed_q;
	assign value         = value_q;
	assign value_written = written_q;

endmodule

`default_nettype wire

/* tb/radix_parse_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_parse_checker
// Watches the character, result and register ports of the radix integer
// parser. It tracks the radix register, predicts the parse result of every
// string from the accepted character transfers, and compares each result
// transfer field by field with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------

module radix_parse_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           char_valid,
	input  logic                           char_ready,
	input  logic [rip_pkg::CHAR_W-1:0]     ch,
	input  logic                           last,
	input  logic                           no_char,
	input  logic                           res_valid,
	input  logic                           res_ready,
	input  logic [rip_pkg::CNT_W-1:0]      consumed,
	input  logic [rip_pkg::VAL_W-1:0]      value,
	input  logic                           value_written,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             results_due
);

	typedef enum logic [2:0] {
		SKIP_WS,
		AFTER_SIGN,
		LEAD_ZERO,
		IN_DIGITS,
		STOPPED
	} scan_phase_t;

	typedef struct packed {
		logic [rip_pkg::CNT_W-1:0] consumed;
		logic [rip_pkg::VAL_W-1:0] value;
		logic                      written;
	} parse_result_t;

	parse_result_t parsed_due_q[$];

	logic [rip_pkg::BASE_W-1:0] radix_reg;
	scan_phase_t                scan_phase;
	logic [rip_pkg::VAL_W-1:0]  acc;
	logic                       neg_sign;
	logic [rip_pkg::BASE_W-1:0] base_sel;
	int unsigned                char_count;
	logic                       zero_wait;

	initial fail_count = 0;

	function automatic int char_value(input logic [rip_pkg::CHAR_W-1:0] c);
		if (c >= rip_pkg::CH_ZERO && c <= rip_pkg::CH_NINE) return int'(c - rip_pkg::CH_ZERO);
		if (c >= rip_pkg::CH_UA && c <= rip_pkg::CH_UZ) return int'(c - rip_pkg::CH_UA) + 10;
		if (c >= rip_pkg::CH_LA && c <= rip_pkg::CH_LZ) return int'(c - rip_pkg::CH_LA) + 10;
		return -1;
	endfunction

	task automatic restart();
		scan_phase = SKIP_WS;
		acc = '0;
		neg_sign = 1'b0;
		base_sel = '0;
		char_count = 0;
		zero_wait = 1'b0;
	endtask

	task automatic bump(input int unsigned k);
		char_count = (char_count + k > rip_pkg::MAX_LEN) ? rip_pkg::MAX_LEN : char_count + k;
	endtask

	task automatic accumulate(input logic [rip_pkg::CHAR_W-1:0] c);
		int d;
		d = char_value(c);
		if (char_count >= rip_pkg::MAX_LEN || d < 0 || d >= int'(base_sel)) begin
			scan_phase = STOPPED;
		end else begin
			acc = acc * rip_pkg::VAL_W'(base_sel) + rip_pkg::VAL_W'(d);
			bump(1);
		end
	endtask

	task automatic first_char(input logic [rip_pkg::CHAR_W-1:0] c);
		if ((radix_reg == rip_pkg::BASE_AUTO || radix_reg == rip_pkg::BASE_HEX)
			&& c == rip_pkg::CH_ZERO) begin
			base_sel = (radix_reg == rip_pkg::BASE_AUTO) ? rip_pkg::BASE_OCT : rip_pkg::BASE_HEX;
			zero_wait = 1'b1;
			scan_phase = LEAD_ZERO;
		end else begin
			base_sel = (radix_reg == rip_pkg::BASE_AUTO) ? rip_pkg::BASE_DEC : radix_reg;
			scan_phase = IN_DIGITS;
			accumulate(c);
		end
	endtask

	task automatic scan_char(input logic [rip_pkg::CHAR_W-1:0] c);
		if (char_count >= rip_pkg::MAX_LEN) begin
			scan_phase = STOPPED;
		end else begin
			case (scan_phase)
				SKIP_WS: begin
					if (c == rip_pkg::CH_SPACE
						|| (c >= rip_pkg::CH_TAB && c <= rip_pkg::CH_CR)) begin
						bump(1);
					end else if (c == rip_pkg::CH_PLUS || c == rip_pkg::CH_MINUS) begin
						neg_sign = (c == rip_pkg::CH_MINUS);
						bump(1);
						scan_phase = AFTER_SIGN;
					end else begin
						first_char(c);
					end
				end
				AFTER_SIGN: first_char(c);
				LEAD_ZERO: begin
					zero_wait = 1'b0;
					if (c == rip_pkg::CH_LX || c == rip_pkg::CH_UX) begin
						bump(2);
						base_sel = rip_pkg::BASE_HEX;
						scan_phase = IN_DIGITS;
					end else begin
						bump(1);
						scan_phase = IN_DIGITS;
						accumulate(c);
					end
				end
				IN_DIGITS: accumulate(c);
				default: ;
			endcase
		end
	endtask

	task automatic take_item();
		parse_result_t r;
		if (!no_char) scan_char(ch);
		if (last) begin
			if (zero_wait) begin
				zero_wait = 1'b0;
				bump(1);
			end
			r.consumed = rip_pkg::CNT_W'(char_count);
			r.value = (char_count == 0) ? '0 :
				(neg_sign ? rip_pkg::VAL_W'(0) - acc : acc);
			r.written = (char_count != 0);
			parsed_due_q.push_back(r);
			restart();
		end
	endtask

	task automatic check_result();
		parse_result_t e;
		if (parsed_due_q.size() == 0) begin
			fail_count++;
			$display("%0t: result with none expected, consumed %0d value %h written %b",
				$time, consumed, value, value_written);
		end else begin
			e = parsed_due_q.pop_front();
			if (consumed !== e.consumed) begin
				fail_count++;
				$display("%0t: consumed expected %0d actual %0d", $time, e.consumed, consumed);
			end
			if (value !== e.value) begin
				fail_count++;
				$display("%0t: value expected %h actual %h", $time, e.value, value);
			end
			if (value_written !== e.written) begin
				fail_count++;
				$display("%0t: value_written expected %b actual %b", $time, e.written,
					value_written);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_reg = rip_pkg::BASE_AUTO;
			restart();
			parsed_due_q.delete();
			results_due = 0;
		end else begin
			if (res_valid && res_ready) check_result();
			if (char_valid && char_ready) take_item();
			if (psel && penable && pwrite && pready && paddr[2] == rip_pkg::RADIX_IDX) begin
				radix_reg = pwdata[rip_pkg::BASE_W-1:0];
			end
			results_due = parsed_due_q.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives strings into the radix integer parser one character per transfer
// and sets the radix register between strings. A short directed set covers
// sign, prefix, whitespace, empty and stop cases, and random strings follow
// across a range of radix settings.
// Both channels idle in random bursts; the checker reports mismatches.
// ----------------------------------------------------------------------------

module testbench;

	localparam logic [rip_pkg::CHAR_W-1:0] CH_LF        = 8'h0A;
	localparam logic [rip_pkg::CHAR_W-1:0] CH_VT        = 8'h0B;
	localparam logic [rip_pkg::CHAR_W-1:0] CH_FF        = 8'h0C;
	localparam int                         RANDOM_ITEMS = 430;

	typedef struct packed {
		logic [rip_pkg::CHAR_W-1:0] c;
		logic                       nc;
	} char_item_t;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       char_valid = 1'b0;
	logic [rip_pkg::CHAR_W-1:0] ch         = '0;
	logic                       last       = 1'b0;
	logic                       no_char    = 1'b0;
	logic                       res_ready  = 1'b0;
	logic                       psel       = 1'b0;
	logic                       penable    = 1'b0;
	logic                       pwrite     = 1'b0;
	logic [2:0]                 paddr      = '0;
	logic [31:0]                pwdata     = '0;

	logic                       char_ready;
	logic                       res_valid;
	logic [rip_pkg::CNT_W-1:0]  consumed;
	logic [rip_pkg::VAL_W-1:0]  value;
	logic                       value_written;
	logic [31:0]                prdata;
	logic                       pready;

	int                         fail_count;
	int                         results_due;
	int                         idle_pct   = 0;
	bit                         calm       = 1'b0;
	int                         hold_left  = 0;
	int                         items_sent = 0;
	logic [rip_pkg::BASE_W-1:0] cur_radix  = rip_pkg::BASE_AUTO;

	logic [rip_pkg::BASE_W-1:0] radix_plan [9] = '{rip_pkg::BASE_HEX, rip_pkg::BASE_DEC,
		6'd1, 6'd36, 6'd63, 6'd37, 6'd2, rip_pkg::BASE_OCT, rip_pkg::BASE_AUTO};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	radix_integer_parser dut (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_ready(char_ready),
		.ch(ch), .last(last), .no_char(no_char),
		.res_valid(res_valid), .res_ready(res_ready),
		.consumed(consumed), .value(value), .value_written(value_written),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	radix_parse_checker parse_monitor (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_ready(char_ready),
		.ch(ch), .last(last), .no_char(no_char),
		.res_valid(res_valid), .res_ready(res_ready),
		.consumed(consumed), .value(value), .value_written(value_written),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .results_due(results_due)
	);

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (!calm && $urandom_range(99) < idle_pct) begin
			hold_left <= $urandom_range(16);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	task automatic send_item(input logic [rip_pkg::CHAR_W-1:0] c, input logic l,
		input logic nc);
		if (!calm && $urandom_range(99) < idle_pct) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(17, 1)) @(negedge clk);
		end
		char_valid <= 1'b1;
		ch <= c;
		last <= l;
		no_char <= nc;
		@(posedge clk);
		while (!char_ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1, 1'b0);
	endtask

	task automatic wait_drained();
		char_valid <= 1'b0;
		@(negedge clk);
		while (results_due != 0) @(negedge clk);
	endtask

	task automatic set_radix(input logic [rip_pkg::BASE_W-1:0] r);
		wait_drained();
		repeat (4) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {rip_pkg::RADIX_IDX, 2'b00};
		pwdata <= 32'(r);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_radix = r;
	endtask

	function automatic logic [rip_pkg::CHAR_W-1:0] ws_char();
		int k;
		k = $urandom_range(6);
		return (k < 5) ? rip_pkg::CH_TAB + 8'(k) : rip_pkg::CH_SPACE;
	endfunction

	function automatic logic [rip_pkg::CHAR_W-1:0] digit_glyph(input int base);
		int d;
		d = $urandom_range((base > 36 ? 36 : base) - 1);
		if (d < 10) return rip_pkg::CH_ZERO + 8'(d);
		return ($urandom_range(1) ? rip_pkg::CH_UA : rip_pkg::CH_LA) + 8'(d - 10);
	endfunction

	task automatic random_string();
		char_item_t text_q[$];
		int n;
		int eff;
		if ($urandom_range(9) == 0) wait_drained();
		if ($urandom_range(7) == 0) begin
			n = $urandom_range(8, 1);
			repeat (n) text_q.push_back('{8'($urandom_range(255)), $urandom_range(7) == 0});
		end else begin
			repeat ($urandom_range(3) == 0 ? $urandom_range(4, 1) : 0) begin
				text_q.push_back('{ws_char(), 1'b0});
			end
			eff = (cur_radix == rip_pkg::BASE_AUTO) ? int'(rip_pkg::BASE_DEC) : int'(cur_radix);
			if ($urandom_range(2) == 0) begin
				text_q.push_back('{($urandom_range(1) ? rip_pkg::CH_MINUS : rip_pkg::CH_PLUS),
					1'b0});
			end
			if ($urandom_range(3) == 0) begin
				text_q.push_back('{rip_pkg::CH_ZERO, 1'b0});
				if (cur_radix == rip_pkg::BASE_AUTO) eff = int'(rip_pkg::BASE_OCT);
				if ($urandom_range(1)) begin
					text_q.push_back('{($urandom_range(1) ? rip_pkg::CH_LX : rip_pkg::CH_UX),
						1'b0});
					if (cur_radix == rip_pkg::BASE_AUTO) eff = int'(rip_pkg::BASE_HEX);
				end
			end
			n = ($urandom_range(7) == 0) ? $urandom_range(26, 14) : $urandom_range(8);
			repeat (n) begin
				if ($urandom_range(15) == 0) text_q.push_back('{8'($urandom_range(255)), 1'b1});
				text_q.push_back('{digit_glyph(eff), 1'b0});
			end
			if ($urandom_range(2) == 0) begin
				repeat ($urandom_range(4, 1)) text_q.push_back('{8'($urandom_range(255)), 1'b0});
			end
		end
		if (text_q.size() == 0 || $urandom_range(4) == 0) begin
			text_q.push_back('{8'($urandom_range(255)), 1'b1});
		end
		foreach (text_q[i]) send_item(text_q[i].c, i == text_q.size() - 1, text_q[i].nc);
	endtask

	initial begin
		int p;
		int random_base;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idle_pct = 20;
		send_text(" \t-42");
		send_text("0x1f");
		send_text("0");
		send_text("017");
		send_text("+0Xg");
		send_item(8'h00, 1'b1, 1'b1);
		send_text("-");
		send_item(CH_VT, 1'b0, 1'b0);
		send_item(CH_FF, 1'b0, 1'b0);
		send_item(CH_LF, 1'b1, 1'b0);
		send_item(rip_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(rip_pkg::CH_NINE, 1'b1, 1'b0);
		send_item(rip_pkg::CH_NINE, 1'b0, 1'b1);
		send_text("12");
		send_text("z");

		random_base = items_sent;
		p = 0;
		while (p < $size(radix_plan) || items_sent - random_base < RANDOM_ITEMS) begin
			set_radix(p < $size(radix_plan) ? radix_plan[p] :
				rip_pkg::BASE_W'($urandom_range(63)));
			case ($urandom_range(2))
				0: idle_pct = 0;
				1: idle_pct = 8;
				default: idle_pct = 30;
			endcase
			repeat (5) random_string();
			p++;
		end

		calm = 1'b1;
		set_radix(rip_pkg::BASE_AUTO);
		repeat (6) random_string();

		wait_drained();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && results_due == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
